// File: src/wfps_pkg.sv
// Package for the windowed FFT power spectrum block.
// Frame geometry, fixed-point widths, twiddle and window tables.
// No dependencies.
package wfps_pkg;

  localparam int FrameLength = 128;
  localparam int FrameBits   = 7;
  localparam int NumBins     = FrameLength / 2;
  // frame sums of windowed samples stay below 2^30 in magnitude
  localparam int WorkWidth   = 32;
  localparam int PowerCap    = (1 << 23) - 1;

  typedef logic signed [WorkWidth-1:0] work_t;

  // sine quarter table in Q1.15, r = 0..32
  function automatic logic [15:0] sin_quarter(input logic [5:0] r);
    logic [15:0] v;
    unique case (r)
      6'd0: v = 16'd0;      6'd1: v = 16'd1608;   6'd2: v = 16'd3212;
      6'd3: v = 16'd4808;   6'd4: v = 16'd6393;   6'd5: v = 16'd7962;
      6'd6: v = 16'd9512;   6'd7: v = 16'd11039;  6'd8: v = 16'd12540;
      6'd9: v = 16'd14010;  6'd10: v = 16'd15447; 6'd11: v = 16'd16846;
      6'd12: v = 16'd18205; 6'd13: v = 16'd19520; 6'd14: v = 16'd20788;
      6'd15: v = 16'd22006; 6'd16: v = 16'd23170; 6'd17: v = 16'd24279;
      6'd18: v = 16'd25330; 6'd19: v = 16'd26320; 6'd20: v = 16'd27246;
      6'd21: v = 16'd28106; 6'd22: v = 16'd28899; 6'd23: v = 16'd29622;
      6'd24: v = 16'd30274; 6'd25: v = 16'd30853; 6'd26: v = 16'd31357;
      6'd27: v = 16'd31786; 6'd28: v = 16'd32138; 6'd29: v = 16'd32413;
      6'd30: v = 16'd32610; 6'd31: v = 16'd32729; 6'd32: v = 16'd32768;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [17:0] sin_q(input logic [6:0] m);
    logic [4:0] r;
    logic [17:0] q;
    logic signed [17:0] v;
    r = m[4:0];
    unique case (m[6:5])
      2'd0: q = {2'b00, sin_quarter({1'b0, r})};
      2'd1: q = {2'b00, sin_quarter(6'd32 - {1'b0, r})};
      2'd2: q = {2'b00, sin_quarter({1'b0, r})};
      default: q = {2'b00, sin_quarter(6'd32 - {1'b0, r})};
    endcase
    v = m[6] ? -$signed(q) : $signed(q);
    return v;
  endfunction

  function automatic logic signed [17:0] cos_q(input logic [6:0] m);
    return sin_q(m + 7'd32);
  endfunction

  function automatic logic [15:0] hann(input logic [6:0] n);
    logic signed [18:0] t;
    logic [17:0] w;
    t = 19'sd32769 - 19'(cos_q(n));
    w = t[18:1];
    return (w > 18'd32767) ? 16'd32767 : w[15:0];
  endfunction

  // round half away from zero, shift right by k
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int k);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (k - 1))) >> k;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// File: src/windowed_fft_power_spectrum.sv
// Hann-windowed 128-point real FFT power spectrum.
// Flow: after the last sample of a frame the front end waits for the engine,
// loads the frame and hands it off; the engine runs 448 butterflies, each through
// BRD, BMUL, PCALC and BWR, then reads, squares and sums each bin in turn.
// Throughput: one sample a cycle while start is high and busy is low; busy is high
// from the last sample until the engine is idle and the stored frame has been read out.
// Synchronous active-high reset clears control state; results cannot be held off.
module windowed_fft_power_spectrum
  import wfps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] sample,
  output logic               valid,
  output logic [5:0]         bin_index,
  output logic [22:0]        power,
  output logic               last_bin
);

  logic ld_we, ld_done, eng_idle;
  logic [FrameBits-1:0] ld_addr;
  work_t ld_data;

  wfps_front u_front (.clk, .rst, .start, .sample, .eng_idle, .busy,
                      .ld_we, .ld_addr, .ld_data, .ld_done);
  wfps_engine u_eng (.clk, .rst, .ld_we, .ld_addr, .ld_data, .ld_done,
                     .eng_idle, .done(valid), .bin_index, .power, .last_bin);

endmodule

// File: src/wfps_front.sv
// Front end: sample capture, window multiply and bit-reversed load.
// Uses wfps_pkg. Feeds the FFT engine through one frame hand-off.
module wfps_front
  import wfps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [15:0]   sample,
  input  logic                 eng_idle,
  output logic                 busy,
  output logic                 ld_we,
  output logic [FrameBits-1:0] ld_addr,
  output work_t                ld_data,
  output logic                 ld_done
);

  typedef enum logic [1:0] {FILL, LOAD, WAIT} state_t;
  state_t state;
  logic [FrameBits-1:0] fill_count;
  logic [FrameBits-1:0] idx;
  logic signed [15:0] sample_store [FrameLength];
  logic signed [15:0] rd;
  logic [FrameBits-1:0] rd_idx, pr_idx;
  logic rd_v, pr_v;
  logic signed [32:0] prod;
  logic signed [63:0] win;

  always_ff @(posedge clk) begin
    if (start && !busy) sample_store[fill_count] <= sample;
    rd <= sample_store[idx];
    prod <= rd * $signed({1'b0, hann(rd_idx)});
    pr_idx <= rd_idx;
  end

  always_comb win = rnd_shift(64'(prod), 8);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FILL; fill_count <= '0; idx <= '0; rd_v <= 1'b0; pr_v <= 1'b0;
      ld_we <= 1'b0; ld_done <= 1'b0;
    end else begin
      ld_we <= pr_v;
      // pulse once the last word of the frame has been written
      ld_done <= !rd_v && !pr_v && ld_we && state == FILL;
      ld_data <= work_t'(win);
      ld_addr <= {<<{pr_idx}};
      rd_v <= (state == LOAD);
      pr_v <= rd_v;
      unique case (state)
        FILL: if (start) begin
          fill_count <= fill_count + 1'b1;
          if (fill_count == 7'(FrameLength - 1)) begin
            state <= WAIT; idx <= '0;
          end
        end
        WAIT: if (eng_idle) state <= LOAD;
        LOAD: begin
          rd_idx <= idx; idx <= idx + 1'b1;
          if (idx == 7'(FrameLength - 1)) state <= FILL;
        end
        default: state <= FILL;
      endcase
    end
  end

  assign busy = (state != FILL);

  a_store_range: assert property (@(posedge clk) disable iff (rst)
    ld_done |-> !ld_we) else $error("done with pending write");
  a_fill_hold: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(fill_count)) else $error("fill count moved while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    ld_done |=> !ld_done) else $error("done not a pulse");

endmodule

// File: src/wfps_engine.sv
// FFT engine: in-place radix-2 butterflies, one butterfly at a time,
// then power per bin. Uses wfps_pkg.
module wfps_engine
  import wfps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ld_we,
  input  logic [FrameBits-1:0] ld_addr,
  input  work_t                ld_data,
  input  logic                 ld_done,
  output logic                 eng_idle,
  output logic                 done,
  output logic [5:0]           bin_index,
  output logic [22:0]          power,
  output logic                 last_bin
);

  typedef enum logic [2:0] {IDLE, BRD, BMUL, BWR, PRD, PCALC, PSQ, PSUM} state_t;
  state_t state;
  work_t re [FrameLength];
  work_t im [FrameLength];
  logic [3:0] lg;
  logic [FrameBits-1:0] grp, j, ia, ib, half, tw;
  work_t ar, ai, br, bi, tr, ti;
  work_t xr, xi;
  logic signed [17:0] c, s;
  logic signed [63:0] pr0, pr1, pi0, pi1;
  logic signed [63:0] sr, si;
  logic [5:0] k;
  logic [63:0] p;

  always_comb begin
    half = 7'(1 << (lg - 1));
    ia = grp + j;
    ib = grp + j + half;
    tw = 7'(j << (4'd7 - lg));
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      re[ld_addr] <= ld_data; im[ld_addr] <= '0;
    end else if (state == BWR) begin
      re[ia] <= ar + tr; im[ia] <= ai + ti;
      re[ib] <= ar - tr; im[ib] <= ai - ti;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE; done <= 1'b0; last_bin <= 1'b0;
    end else begin
      done     <= (state == PSUM);
      last_bin <= (state == PSUM) && k == 6'(NumBins - 1);
      unique case (state)
        IDLE: if (ld_done) begin
          state <= BRD; lg <= 4'd1; grp <= '0; j <= '0;
        end
        BRD: begin
          ar <= re[ia]; ai <= im[ia]; br <= re[ib]; bi <= im[ib];
          c <= cos_q(tw); s <= sin_q(tw);
          state <= BMUL;
        end
        BMUL: begin
          pr0 <= br * c; pr1 <= bi * s;
          pi0 <= bi * c; pi1 <= br * s;
          state <= PCALC;
        end
        PCALC: begin
          tr <= work_t'(rnd_shift(pr0 + pr1, 15));
          ti <= work_t'(rnd_shift(pi0 - pi1, 15));
          state <= BWR;
        end
        BWR: begin
          if (j == half - 1'b1) begin
            j <= '0;
            if (8'(grp) + 8'(half) + 8'(half) >= 8'(FrameLength)) begin
              grp <= '0;
              if (lg == 4'(FrameBits)) begin
                state <= PRD; k <= '0;
              end else begin
                state <= BRD; lg <= lg + 1'b1;
              end
            end else begin
              state <= BRD; grp <= grp + 7'(half << 1);
            end
          end else begin
            state <= BRD; j <= j + 1'b1;
          end
        end
        PRD: begin
          xr <= re[{1'b0, k}]; xi <= im[{1'b0, k}];
          state <= PSQ;
        end
        PSQ: begin
          // DC uses the real part only
          sr <= xr * xr;
          si <= (k == 6'd0) ? 64'sd0 : xi * xi;
          state <= PSUM;
        end
        PSUM: begin
          p <= $unsigned(sr + si);
          bin_index <= k;
          if (k == 6'(NumBins - 1)) state <= IDLE;
          else begin
            state <= PRD; k <= k + 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  logic [63:0] q;
  always_comb q = (p + (64'd1 << 21)) >> 22;
  assign power = (q > 64'(PowerCap)) ? 23'(PowerCap) : q[22:0];
  assign eng_idle = (state == IDLE) && !done;

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    ld_we |-> state == IDLE) else $error("load during transform");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    last_bin |-> done) else $error("last without strobe");
  a_lg_range: assert property (@(posedge clk) disable iff (rst)
    state == BWR |-> lg != 4'd0) else $error("stage zero");

endmodule
